/* hdl/tpw_pkg.sv */
// shared types and constants for the threshold pair weight update block
`default_nettype none

package tpw_pkg;

    localparam int W_WIDTH       = 32;
    localparam int Z_WIDTH       = 48;
    localparam int ACC_WIDTH_DEF = 48;
    localparam int IDX_WIDTH     = 3;

    localparam logic [W_WIDTH-1:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [63:0]        ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0]        Z_MAX   = 64'h0000_FFFF_FFFF_FFFF;

    localparam logic [IDX_WIDTH-1:0] REG_THETA_LOW        = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_THETA_HIGH       = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_NO_VOTE_DEFAULT  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_FACTOR_CORRECT   = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_FACTOR_INCORRECT = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_CAP_ENABLE       = 3'd5;

    localparam logic [W_WIDTH-1:0] THETA_LOW_RST  = 32'h0000_0000;
    localparam logic [W_WIDTH-1:0] THETA_HIGH_RST = 32'h7FFF_FFFF;

    typedef struct packed {
        logic               en;
        logic               changed;
        logic               last;
        logic [W_WIDTH-1:0] weight;
        logic [W_WIDTH-1:0] new_weight;
    } t_acc_step;

endpackage

`default_nettype wire

/* hdl/tpw_ifs.sv */
// channel interfaces for pair input, result output and register writes
`default_nettype none

interface tpw_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] left_value;
    logic        left_votes;
    logic signed [31:0] right_value;
    logic        right_votes;
    logic [31:0] cur_weight;
    logic [31:0] weight_cap;
    logic        last_pair;

    modport source (
        output valid, left_value, left_votes, right_value, right_votes,
        output cur_weight, weight_cap, last_pair,
        input  ready
    );
    modport sink (
        input  valid, left_value, left_votes, right_value, right_votes,
        input  cur_weight, weight_cap, last_pair,
        output ready
    );
endinterface

interface tpw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_weight;
    logic        pair_changed;
    logic        pass_done;
    logic [47:0] z_total;

    modport source (
        output valid, new_weight, pair_changed, pass_done, z_total,
        input  ready
    );
    modport sink (
        input  valid, new_weight, pair_changed, pass_done, z_total,
        output ready
    );
endinterface

interface tpw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/tpw_accum.sv */
// running weight sums with saturation and the normaliser for the last pair
`default_nettype none

module tpw_accum #(
    parameter int ACC_WIDTH = tpw_pkg::ACC_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tpw_pkg::t_acc_step             i_step,
    output logic [tpw_pkg::Z_WIDTH-1:0]    o_z
);

    localparam int XW = ((ACC_WIDTH > tpw_pkg::Z_WIDTH) ? ACC_WIDTH : tpw_pkg::Z_WIDTH) + 2;
    localparam logic [XW-1:0] ONE_X  = XW'(tpw_pkg::ONE_Q32);
    localparam logic [XW-1:0] ZMAX_X = XW'(tpw_pkg::Z_MAX);
    localparam logic [XW-1:0] ZLIM_X = XW'(tpw_pkg::Z_MAX - tpw_pkg::ONE_Q32);

    logic [ACC_WIDTH-1:0] r_sum_before;
    logic [ACC_WIDTH-1:0] r_sum_after;
    logic [ACC_WIDTH-1:0] r_snap_before;
    logic [ACC_WIDTH-1:0] r_snap_after;
    logic                 r_snap_last;

    logic [ACC_WIDTH:0]   add_before;
    logic [ACC_WIDTH:0]   add_after;
    logic [ACC_WIDTH-1:0] upd_before;
    logic [ACC_WIDTH-1:0] upd_after;
    logic [ACC_WIDTH-1:0] n_sum_before;
    logic [ACC_WIDTH-1:0] n_sum_after;

    logic [XW-1:0]        sb;
    logic [XW-1:0]        sa;
    logic [XW-1:0]        diff_ba;
    logic [XW-1:0]        diff_ab;
    logic [XW-1:0]        z_x;

    // saturating add of this pair's weights
    always_comb begin
        add_before = {1'b0, r_sum_before} + (ACC_WIDTH+1)'(i_step.weight);
        add_after  = {1'b0, r_sum_after}  + (ACC_WIDTH+1)'(i_step.new_weight);
        upd_before = r_sum_before;
        upd_after  = r_sum_after;
        if (i_step.changed) begin
            upd_before = add_before[ACC_WIDTH] ? '1 : add_before[ACC_WIDTH-1:0];
            upd_after  = add_after[ACC_WIDTH]  ? '1 : add_after[ACC_WIDTH-1:0];
        end
        n_sum_before = i_step.last ? '0 : upd_before;
        n_sum_after  = i_step.last ? '0 : upd_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_before <= '0;
            r_sum_after  <= '0;
        end else if (i_step.en) begin
            r_sum_before <= n_sum_before;
            r_sum_after  <= n_sum_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.en) begin
            r_snap_before <= upd_before;
            r_snap_after  <= upd_after;
            r_snap_last   <= i_step.last;
        end
    end

    // z = 1 - before + after, clamped
    always_comb begin
        sb      = XW'(r_snap_before);
        sa      = XW'(r_snap_after);
        diff_ba = sb - sa;
        diff_ab = sa - sb;
        if (sb > sa) begin
            z_x = (diff_ba >= ONE_X) ? '0 : (ONE_X - diff_ba);
        end else begin
            z_x = (diff_ab > ZLIM_X) ? ZMAX_X : (ONE_X + diff_ab);
        end
        o_z = r_snap_last ? z_x[tpw_pkg::Z_WIDTH-1:0] : '0;
    end

endmodule

`default_nettype wire

/* hdl/threshold_pair_weight_update.sv */
// top level of the threshold pair weight update block
//
// Takes one pair word per cycle unless the result side stalls, and returns one result word per
// pair, in order. A result word passes six registers after its pair is accepted: input
// register, vote and operand select, the 32x32 multiply, weight saturation, the running sums,
// then the result register. The running sums are updated in a single stage, so consecutive
// pairs never wait on each other. Each stage holds its word while the next is full, so
// back-pressure on the result side stalls only as far as needed.
// Registers are written through the configuration channel, which is always ready.
`default_nettype none

module threshold_pair_weight_update #(
    parameter int ACC_WIDTH = tpw_pkg::ACC_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpw_cfg_if.sink    i_cfg,
    tpw_in_if.sink     i_in,
    tpw_out_if.source  o_out
);

    localparam int WW = tpw_pkg::W_WIDTH;

    // configuration
    logic signed [WW-1:0] r_theta_low;
    logic signed [WW-1:0] r_theta_high;
    logic                 r_no_vote_default;
    logic [WW-1:0]        r_factor_correct;
    logic [WW-1:0]        r_factor_incorrect;
    logic                 r_cap_enable;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdyo;

    // stage 1: input register
    logic signed [WW-1:0] r_s1_left_value;
    logic                 r_s1_left_votes;
    logic signed [WW-1:0] r_s1_right_value;
    logic                 r_s1_right_votes;
    logic [WW-1:0]        r_s1_weight;
    logic [WW-1:0]        r_s1_cap;
    logic                 r_s1_last;

    logic                 h0;
    logic                 h1;
    logic [WW-1:0]        factor;
    logic                 capped;
    logic [WW-1:0]        op_a;
    logic [WW-1:0]        op_b;

    // stage 2: operands
    logic [WW-1:0]        r_s2_op_a;
    logic [WW-1:0]        r_s2_op_b;
    logic [WW-1:0]        r_s2_weight;
    logic                 r_s2_changed;
    logic                 r_s2_capped;
    logic                 r_s2_last;

    // stage 3: product
    logic [2*WW-1:0]      r_s3_prod;
    logic [WW-1:0]        r_s3_weight;
    logic                 r_s3_changed;
    logic                 r_s3_capped;
    logic                 r_s3_last;

    logic [2*WW-25:0]     shifted;
    logic [2*WW-24:0]     cap_sum;
    logic [WW-1:0]        n_weight;

    // stage 4: updated weight
    logic [WW-1:0]        r_s4_new_weight;
    logic [WW-1:0]        r_s4_weight;
    logic                 r_s4_changed;
    logic                 r_s4_last;

    // stage 5: sums taken
    logic [WW-1:0]        r_s5_new_weight;
    logic                 r_s5_changed;
    logic                 r_s5_last;

    // result register
    logic [WW-1:0]               r_o_new_weight;
    logic                        r_o_pair_changed;
    logic                        r_o_pass_done;
    logic [tpw_pkg::Z_WIDTH-1:0] r_o_z_total;

    tpw_pkg::t_acc_step          acc_step;
    logic [tpw_pkg::Z_WIDTH-1:0] z_value;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta_low        <= tpw_pkg::THETA_LOW_RST;
            r_theta_high       <= tpw_pkg::THETA_HIGH_RST;
            r_no_vote_default  <= 1'b0;
            r_factor_correct   <= tpw_pkg::ONE_Q24;
            r_factor_incorrect <= tpw_pkg::ONE_Q24;
            r_cap_enable       <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tpw_pkg::REG_THETA_LOW:        r_theta_low        <= i_cfg.data;
                tpw_pkg::REG_THETA_HIGH:       r_theta_high       <= i_cfg.data;
                tpw_pkg::REG_NO_VOTE_DEFAULT:  r_no_vote_default  <= i_cfg.data[0];
                tpw_pkg::REG_FACTOR_CORRECT:   r_factor_correct   <= i_cfg.data;
                tpw_pkg::REG_FACTOR_INCORRECT: r_factor_incorrect <= i_cfg.data;
                tpw_pkg::REG_CAP_ENABLE:       r_cap_enable       <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // a stage takes a word when empty or when its word moves on
    assign rdyo = !r_vo || o_out.ready;
    assign rdy5 = !r_v5 || rdyo;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_in.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdyo) r_vo <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_left_value  <= i_in.left_value;
            r_s1_left_votes  <= i_in.left_votes;
            r_s1_right_value <= i_in.right_value;
            r_s1_right_votes <= i_in.right_votes;
            r_s1_weight      <= i_in.cur_weight;
            r_s1_cap         <= i_in.weight_cap;
            r_s1_last        <= i_in.last_pair;
        end
    end

    // votes and multiplier operands
    always_comb begin
        h0 = r_s1_left_votes
           ? ((r_s1_left_value > r_theta_low) && (r_s1_left_value <= r_theta_high))
           : r_no_vote_default;
        h1 = r_s1_right_votes
           ? ((r_s1_right_value > r_theta_low) && (r_s1_right_value <= r_theta_high))
           : r_no_vote_default;
        factor = h1 ? r_factor_correct : r_factor_incorrect;
        capped = r_cap_enable && (r_s1_weight >= r_s1_cap) && (factor > tpw_pkg::ONE_Q24);
        op_a   = capped ? (factor - tpw_pkg::ONE_Q24) : factor;
        op_b   = capped ? r_s1_cap : r_s1_weight;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_op_a    <= op_a;
            r_s2_op_b    <= op_b;
            r_s2_weight  <= r_s1_weight;
            r_s2_changed <= (h0 != h1);
            r_s2_capped  <= capped;
            r_s2_last    <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_prod    <= r_s2_op_a * r_s2_op_b;
            r_s3_weight  <= r_s2_weight;
            r_s3_changed <= r_s2_changed;
            r_s3_capped  <= r_s2_capped;
            r_s3_last    <= r_s2_last;
        end
    end

    // q8.56 product back to q0.32, added to the weight when capped, saturated
    always_comb begin
        shifted = r_s3_prod[2*WW-1:24];
        cap_sum = (2*WW-23)'(r_s3_weight) + (2*WW-23)'(shifted);
        if (!r_s3_changed) begin
            n_weight = r_s3_weight;
        end else if (r_s3_capped) begin
            n_weight = (|cap_sum[2*WW-24:WW]) ? '1 : cap_sum[WW-1:0];
        end else begin
            n_weight = (|shifted[2*WW-25:WW]) ? '1 : shifted[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_new_weight <= n_weight;
            r_s4_weight     <= r_s3_weight;
            r_s4_changed    <= r_s3_changed;
            r_s4_last       <= r_s3_last;
        end
    end

    always_comb begin
        acc_step.en         = r_v4 && rdy5;
        acc_step.changed    = r_s4_changed;
        acc_step.last       = r_s4_last;
        acc_step.weight     = r_s4_weight;
        acc_step.new_weight = r_s4_new_weight;
    end

    tpw_accum #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (acc_step),
        .o_z     (z_value)
    );

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_s5_new_weight <= r_s4_new_weight;
            r_s5_changed    <= r_s4_changed;
            r_s5_last       <= r_s4_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdyo) begin
            r_o_new_weight   <= r_s5_new_weight;
            r_o_pair_changed <= r_s5_changed;
            r_o_pass_done    <= r_s5_last;
            r_o_z_total      <= z_value;
        end
    end

    assign o_out.valid        = r_vo;
    assign o_out.new_weight   = r_o_new_weight;
    assign o_out.pair_changed = r_o_pair_changed;
    assign o_out.pass_done    = r_o_pass_done;
    assign o_out.z_total      = r_o_z_total;

endmodule

`default_nettype wire
